[rtl/cid_pkg.sv]
// Shared types and constants for the coverage island detector.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cid_pkg;

  localparam int POS_W   = 32;
  localparam int COV_W   = 24;
  localparam int SUM_W   = 56;
  localparam int CFG_W   = 16;
  localparam int MEAN_W  = 24;
  localparam int INDEX_W = 2;

  localparam int SCALE_DEF       = 1000;
  localparam int QUEUE_DEPTH_DEF = 2;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_READ_LENGTH = 2'd0;
  localparam logic [INDEX_W-1:0] REG_MIN_LENGTH  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_MAX_LENGTH  = 2'd2;
  localparam logic [INDEX_W-1:0] REG_MAX_GAP     = 2'd3;

  localparam logic [CFG_W-1:0] READ_LENGTH_RST = 16'd100;
  localparam logic [CFG_W-1:0] MIN_LENGTH_RST  = 16'd20;
  localparam logic [CFG_W-1:0] MAX_LENGTH_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] MAX_GAP_RST     = 16'd5;

  typedef struct packed {
    logic [CFG_W-1:0] read_length;
    logic [CFG_W-1:0] min_length;
    logic [CFG_W-1:0] max_length;
    logic [CFG_W-1:0] max_gap;
  } cfg_t;

  // one closed island that passed the length filter
  typedef struct packed {
    logic [POS_W-1:0] begin_pos;
    logic [POS_W-1:0] end_pos;
    logic [SUM_W-1:0] sum;
  } island_t;

endpackage

`default_nettype wire

[rtl/cid_front.sv]
// Front end: accepts coverage items, tracks the open island and filters closures.
// Pushes surviving islands into the queue; depends on cid_pkg.
`default_nettype none

module cid_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cid_pkg::cfg_t             cfg,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [cid_pkg::COV_W-1:0] coverage,
  input  wire logic                      last_in_sequence,
  input  wire logic                      queue_full,
  output logic                           push,
  output cid_pkg::island_t               push_data
);

  logic [cid_pkg::POS_W-1:0] position, position_next;
  logic                      in_island, in_island_next;
  logic [cid_pkg::POS_W-1:0] start_pos, start_pos_next;
  logic [cid_pkg::POS_W-1:0] stop_pos, stop_pos_next;
  logic [cid_pkg::SUM_W-1:0] coverage_sum, coverage_sum_next;
  logic [cid_pkg::CFG_W-1:0] gap_count, gap_count_next;

  logic                      accept;
  logic [cid_pkg::CFG_W-1:0] gap_inc;
  logic                      gap_close;
  logic [cid_pkg::POS_W-1:0] span_cur;
  logic [cid_pkg::POS_W-1:0] span_next;
  logic                      too_short;
  logic                      emit_gap;
  logic                      emit_last;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  assign gap_inc   = (gap_count == '1) ? gap_count : gap_count + 1'b1;
  assign gap_close = in_island && (coverage == '0) && (gap_inc > cfg.max_gap);
  assign span_cur  = stop_pos - start_pos;
  assign too_short = ({1'b0, span_cur} + 33'd1) < {17'd0, cfg.min_length};
  assign emit_gap  = gap_close && !too_short;

  always_comb begin
    in_island_next    = in_island;
    start_pos_next    = start_pos;
    stop_pos_next     = stop_pos;
    coverage_sum_next = coverage_sum;
    gap_count_next    = gap_count;
    if (coverage != '0) begin
      in_island_next = 1'b1;
      stop_pos_next  = position;
      gap_count_next = '0;
      if (in_island) begin
        coverage_sum_next = coverage_sum + cid_pkg::SUM_W'(coverage);
      end else begin
        start_pos_next    = position;
        coverage_sum_next = cid_pkg::SUM_W'(coverage);
      end
    end else if (in_island) begin
      gap_count_next = gap_close ? '0 : gap_inc;
      in_island_next = !gap_close;
    end
    span_next = stop_pos_next - start_pos_next;
    emit_last = last_in_sequence && in_island_next &&
                (span_next > cid_pkg::POS_W'(cfg.min_length));
    // end of sequence: flush, then restart counting
    if (last_in_sequence) begin
      in_island_next = 1'b0;
      gap_count_next = '0;
      position_next  = '0;
    end else begin
      position_next = position + 1'b1;
    end
  end

  assign push      = accept && (emit_gap || emit_last);
  assign push_data = {start_pos_next, stop_pos_next, coverage_sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      in_island    <= 1'b0;
      start_pos    <= '0;
      stop_pos     <= '0;
      coverage_sum <= '0;
      gap_count    <= '0;
    end else if (accept) begin
      position     <= position_next;
      in_island    <= in_island_next;
      start_pos    <= start_pos_next;
      stop_pos     <= stop_pos_next;
      coverage_sum <= coverage_sum_next;
      gap_count    <= gap_count_next;
    end
  end

endmodule

`default_nettype wire

[rtl/cid_queue.sv]
// Short first-in first-out queue of closed islands between front and back.
// Depends on cid_pkg for the island record type.
`default_nettype none

module cid_queue #(
  parameter int DEPTH = cid_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire cid_pkg::island_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output cid_pkg::island_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cid_pkg::island_t   entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    advance = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (pop && !empty) begin
        rd_ptr <= advance(rd_ptr);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/cid_back.sv]
// Back end: takes queued islands, divides the coverage sum one bit per cycle
// and presents the result in an output register. Depends on cid_pkg.
`default_nettype none

module cid_back #(
  parameter int SCALE = cid_pkg::SCALE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cid_pkg::cfg_t              cfg,
  input  wire logic                       queue_empty,
  input  wire cid_pkg::island_t           queue_data,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [cid_pkg::POS_W-1:0]       island_begin,
  output logic [cid_pkg::POS_W-1:0]       island_end,
  output logic [cid_pkg::MEAN_W-1:0]      mean_coverage,
  output logic                            too_long
);

  localparam int SCALE_W = $clog2(SCALE + 1);
  localparam int DIV_W   = SCALE_W + cid_pkg::CFG_W;
  localparam int SUM_W   = cid_pkg::SUM_W;
  localparam int CNT_W   = $clog2(SUM_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  state_t                     state;
  cid_pkg::island_t           rec;
  logic [DIV_W-1:0]           divisor;
  logic [DIV_W-1:0]           rem;
  logic [SUM_W-1:0]           quo;
  logic [CNT_W-1:0]           cnt;

  logic [cid_pkg::CFG_W-1:0]  rl_eff;
  logic [DIV_W:0]             rem_sh;
  logic                       ge;
  logic [cid_pkg::POS_W-1:0]  span;
  logic                       out_free;

  assign rl_eff   = (cfg.read_length == '0) ? cid_pkg::CFG_W'(1) : cfg.read_length;
  assign rem_sh   = {rem, quo[SUM_W-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign span     = rec.end_pos - rec.begin_pos;
  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == S_IDLE) && !queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!queue_empty) begin
            rec   <= queue_data;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          divisor <= DIV_W'(SCALE) * DIV_W'(rl_eff);
          rem     <= '0;
          quo     <= rec.sum;
          cnt     <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          // restoring step: one quotient bit per cycle, MSB first
          rem <= ge ? DIV_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_W-1:0];
          quo <= {quo[SUM_W-2:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SUM_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            island_begin  <= rec.begin_pos;
            island_end    <= rec.end_pos;
            mean_coverage <= (quo[SUM_W-1:cid_pkg::MEAN_W] != '0) ? '1
                                                                : quo[cid_pkg::MEAN_W-1:0];
            too_long      <= ({1'b0, span} + 33'd1) > {17'd0, cfg.max_length};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/coverage_island_detector.sv]
// Coverage island detector: finds gap-tolerant runs of covered positions.
// Top level; instantiates cid_front, cid_queue and cid_back, uses cid_pkg.
//
// Input channel: one coverage value per position with last_in_sequence on the
// final position of a sequence; an item moves when in_valid is high and
// in_stall is low. The front end takes one item per cycle and stalls only when
// the island queue (QUEUE_DEPTH entries) is full.
// Output channel: one item per reported island (begin, end, mean coverage,
// too_long flag), moved when out_valid is high and out_stall is low.
// After the edge that takes the closing item, the back end takes the island
// from the queue, forms SCALE * read_length, runs a bit-serial restoring
// divider over the 56-bit coverage sum and loads the output register, where
// out_valid rises. The back end takes the next island from the queue only
// when it is through with the last one; positions flow at one per cycle as
// long as the queue has room.
// While the receiver stalls, the output register holds its item; the divider
// may finish the next island and waits, and the front end keeps taking items
// until the queue fills.
// Reset clears the position counter, the open island, the queue and the output
// valid, and loads the registers with their defaults; no clearing pass.
// Configuration writes are taken at once through cfg_we/cfg_index/cfg_data.
`default_nettype none

module coverage_island_detector #(
  parameter int SCALE       = cid_pkg::SCALE_DEF,
  parameter int QUEUE_DEPTH = cid_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [cid_pkg::INDEX_W-1:0] cfg_index,
  input  wire logic [cid_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [cid_pkg::COV_W-1:0]   coverage,
  input  wire logic                        last_in_sequence,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [cid_pkg::POS_W-1:0]        island_begin,
  output logic [cid_pkg::POS_W-1:0]        island_end,
  output logic [cid_pkg::MEAN_W-1:0]       mean_coverage,
  output logic                             too_long
);

  cid_pkg::cfg_t    cfg;
  logic             queue_full;
  logic             queue_empty;
  logic             push;
  logic             pop;
  cid_pkg::island_t push_data;
  cid_pkg::island_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_length <= cid_pkg::READ_LENGTH_RST;
      cfg.min_length  <= cid_pkg::MIN_LENGTH_RST;
      cfg.max_length  <= cid_pkg::MAX_LENGTH_RST;
      cfg.max_gap     <= cid_pkg::MAX_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cid_pkg::REG_READ_LENGTH: cfg.read_length <= cfg_data;
        cid_pkg::REG_MIN_LENGTH:  cfg.min_length  <= cfg_data;
        cid_pkg::REG_MAX_LENGTH:  cfg.max_length  <= cfg_data;
        cid_pkg::REG_MAX_GAP:     cfg.max_gap     <= cfg_data;
        default:                  cfg             <= cfg;
      endcase
    end
  end

  cid_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .coverage         (coverage),
    .last_in_sequence (last_in_sequence),
    .queue_full       (queue_full),
    .push             (push),
    .push_data        (push_data)
  );

  cid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .pop_data  (pop_data)
  );

  cid_back #(
    .SCALE (SCALE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .queue_empty   (queue_empty),
    .queue_data    (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .island_begin  (island_begin),
    .island_end    (island_end),
    .mean_coverage (mean_coverage),
    .too_long      (too_long)
  );

endmodule

`default_nettype wire

[tb/sv/cid_island_checker.sv]
// Island checker for the coverage island detector testbench.
// Watches the config port and both item channels, predicts the reported islands
// and compares them in order; depends on cid_pkg.
module cid_island_checker #(
  parameter int SCALE = cid_pkg::SCALE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [cid_pkg::INDEX_W-1:0] cfg_index,
  input  wire logic [cid_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [cid_pkg::COV_W-1:0]   coverage,
  input  wire logic                        last_in_sequence,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [cid_pkg::POS_W-1:0]   island_begin,
  input  wire logic [cid_pkg::POS_W-1:0]   island_end,
  input  wire logic [cid_pkg::MEAN_W-1:0]  mean_coverage,
  input  wire logic                        too_long,
  output int                               mismatches,
  output int                               outstanding
);
  import cid_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]  begin_pos;
    logic [POS_W-1:0]  end_pos;
    logic [MEAN_W-1:0] mean;
    logic              too_long;
  } island_report_t;

  logic [CFG_W-1:0] read_len;
  logic [CFG_W-1:0] min_len;
  logic [CFG_W-1:0] max_len;
  logic [CFG_W-1:0] gap_limit;

  logic [POS_W-1:0] position;
  logic             in_island;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] stop_pos;
  logic [SUM_W-1:0] cov_sum;
  logic [CFG_W-1:0] gap_run;

  island_report_t pending_islands[$];

  // Apply the length filter to the open island and form its report.
  function automatic bit measure_island(output island_report_t rpt);
    logic [POS_W:0]   span_len;
    logic [SUM_W-1:0] divisor;
    logic [SUM_W-1:0] quotient;
    span_len = {1'b0, stop_pos - start_pos} + 1'b1;
    rpt = '0;
    if (span_len < {17'd0, min_len}) return 1'b0;
    divisor = SUM_W'(SCALE) * SUM_W'((read_len == '0) ? 16'd1 : read_len);
    quotient = cov_sum / divisor;
    rpt.begin_pos = start_pos;
    rpt.end_pos = stop_pos;
    rpt.mean = (quotient > SUM_W'(24'hFFFFFF)) ? '1 : quotient[MEAN_W-1:0];
    rpt.too_long = span_len > {17'd0, max_len};
    return 1'b1;
  endfunction

  task automatic advance_position(input logic [COV_W-1:0] cov, input logic last_flag);
    island_report_t rpt;
    bit             found;
    found = 1'b0;
    if (cov != '0) begin
      if (in_island) begin
        stop_pos = position;
        cov_sum = cov_sum + SUM_W'(cov);
      end else begin
        in_island = 1'b1;
        start_pos = position;
        stop_pos = position;
        cov_sum = SUM_W'(cov);
      end
      gap_run = '0;
    end else if (in_island) begin
      if (gap_run != '1) gap_run++;
      if (gap_run > gap_limit) begin
        found = measure_island(rpt);
        in_island = 1'b0;
        gap_run = '0;
      end
    end
    if (last_flag) begin
      // flush at end of sequence only when the span is strictly above min_length
      if (in_island && (stop_pos - start_pos) > {16'd0, min_len})
        found = measure_island(rpt);
      in_island = 1'b0;
      gap_run = '0;
      position = '0;
    end else begin
      position++;
    end
    if (found) pending_islands = {pending_islands, rpt};
  endtask

  task automatic flag_mismatch(input string what, input island_report_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected begin %0d end %0d mean %0d too_long %0b, %s",
               what, want.begin_pos, want.end_pos, want.mean, want.too_long,
               $sformatf("got begin %0d end %0d mean %0d too_long %0b",
                         island_begin, island_end, mean_coverage, too_long));
  endtask

  task automatic check_island();
    island_report_t want;
    if (pending_islands.size() == 0) begin
      flag_mismatch("island with none expected", '0);
    end else begin
      want = pending_islands.pop_front();
      if (island_begin !== want.begin_pos || island_end !== want.end_pos ||
          mean_coverage !== want.mean || too_long !== want.too_long)
        flag_mismatch("island differs", want);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      read_len = READ_LENGTH_RST;
      min_len = MIN_LENGTH_RST;
      max_len = MAX_LENGTH_RST;
      gap_limit = MAX_GAP_RST;
      position = '0;
      in_island = 1'b0;
      start_pos = '0;
      stop_pos = '0;
      cov_sum = '0;
      gap_run = '0;
      pending_islands.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) check_island();
      if (cfg_we) begin
        case (cfg_index)
          REG_READ_LENGTH: read_len = cfg_data;
          REG_MIN_LENGTH:  min_len = cfg_data;
          REG_MAX_LENGTH:  max_len = cfg_data;
          REG_MAX_GAP:     gap_limit = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) advance_position(coverage, last_in_sequence);
    end
    outstanding = pending_islands.size();
  end

endmodule

[tb/sv/coverage_island_detector_test.sv]
// Top of the coverage island detector testbench: clock, reset, config writes,
// coverage stimulus and output stalls; checking is done by cid_island_checker.
// Depends on cid_pkg, coverage_island_detector and cid_island_checker.
module coverage_island_detector_test;
  import cid_pkg::*;

  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 70;
  localparam int LIMIT_CYCLES    = 600_000;

  // {last_in_sequence, coverage}
  localparam logic [COV_W:0] DIRECTED_ITEMS [25] = '{
    25'h0FFFFFF, 25'h0000000, 25'h0000001, 25'h0000000, 25'h0000005,
    25'h0000000, 25'h0000000, 25'h0000007, 25'h0000007, 25'h0000000,
    25'h0000000, 25'h0000009, 25'h0000009, 25'h0000009, 25'h0000000,
    25'h0000000, 25'h0000003, 25'h0000003, 25'h1000003, 25'h0000004,
    25'h0000004, 25'h0000004, 25'h0000004, 25'h1000004, 25'h1FFFFFF
  };

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [INDEX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [COV_W-1:0]    coverage;
  logic                last_in_sequence;
  logic                out_valid;
  logic                out_stall;
  logic [POS_W-1:0]    island_begin;
  logic [POS_W-1:0]    island_end;
  logic [MEAN_W-1:0]   mean_coverage;
  logic                too_long;
  int                  mismatches;
  int                  outstanding;

  int unsigned in_idle_max;
  int unsigned out_idle_max;
  int unsigned items_sent;
  bit          hold_off_req;
  int unsigned cur_min;
  int unsigned cur_gap;

  coverage_island_detector uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .coverage         (coverage),
    .last_in_sequence (last_in_sequence),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .island_begin     (island_begin),
    .island_end       (island_end),
    .mean_coverage    (mean_coverage),
    .too_long         (too_long)
  );

  cid_island_checker island_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .coverage         (coverage),
    .last_in_sequence (last_in_sequence),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .island_begin     (island_begin),
    .island_end       (island_end),
    .mean_coverage    (mean_coverage),
    .too_long         (too_long),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("coverage_island_detector: mismatch");
    $finish;
  end

  function automatic logic [COV_W-1:0] rand_cov();
    logic [COV_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = '1;
      1: v = COV_W'($urandom_range(1, 255));
      default: v = COV_W'($urandom);
    endcase
    if (v == '0) v = 24'd1;
    return v;
  endfunction

  function automatic int unsigned pick_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 18;
    endcase
  endfunction

  task automatic send_item(input logic [COV_W-1:0] cov, input logic last_flag);
    int unsigned idle;
    idle = $urandom_range(0, in_idle_max);
    @(negedge clk);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    coverage <= cov;
    last_in_sequence <= last_flag;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic program_thresholds(input logic [CFG_W-1:0] rl, input logic [CFG_W-1:0] min_l,
                                    input logic [CFG_W-1:0] max_l, input logic [CFG_W-1:0] gap);
    write_reg(REG_READ_LENGTH, rl);
    write_reg(REG_MIN_LENGTH, min_l);
    write_reg(REG_MAX_LENGTH, max_l);
    write_reg(REG_MAX_GAP, gap);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_min = min_l;
    cur_gap = gap;
  endtask

  // Drop valid, wait for every expected island, then let dropped ones drain.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Covered run with short tolerated gaps inside.
  task automatic send_island(input int unsigned len);
    int unsigned zeros_cap;
    zeros_cap = (cur_gap > 6) ? 6 : cur_gap;
    for (int unsigned i = 0; i < len; i++) begin
      if (i > 0 && zeros_cap > 0 && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, zeros_cap)) send_item('0, 1'b0);
      send_item(rand_cov(), 1'b0);
    end
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned len_cap;
    stop_at = items_sent + n_items;
    len_cap = (cur_min > 52) ? 64 : cur_min + 12;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: send_item($urandom_range(0, 1) ? rand_cov() : '0, $urandom_range(0, 15) == 0);
        1: begin
          // broken: separator too short to close the island
          send_island($urandom_range(1, len_cap));
          repeat ($urandom_range(0, (cur_gap > 6) ? 6 : cur_gap)) send_item('0, 1'b0);
        end
        default: begin
          send_island($urandom_range(1, len_cap));
          if (cur_gap > 40 || $urandom_range(0, 5) == 0)
            send_item($urandom_range(0, 1) ? rand_cov() : '0, 1'b1);
          else
            repeat (cur_gap + 1 + $urandom_range(0, 2)) send_item('0, 1'b0);
        end
      endcase
    end
  endtask

  // Output side: per item stall draw, plus one long hold-off on request.
  initial begin
    int unsigned idle;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        idle = $urandom_range(0, out_idle_max);
        if (idle > 0) begin
          out_stall <= 1'b1;
          repeat (idle) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    coverage = '0;
    last_in_sequence = 1'b0;
    in_idle_max = 3;
    out_idle_max = 3;
    items_sent = 0;
    hold_off_req = 1'b0;
    cur_min = MIN_LENGTH_RST;
    cur_gap = MAX_GAP_RST;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // zero read length, tight thresholds: gap reset inside an island, length
    // filter at the limit, too-long flag, end-of-sequence flush either side
    program_thresholds(16'd0, 16'd3, 16'd4, 16'd1);
    for (int i = 0; i < 25; i++)
      send_item(DIRECTED_ITEMS[i][COV_W-1:0], DIRECTED_ITEMS[i][COV_W]);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: program_thresholds(READ_LENGTH_RST, MIN_LENGTH_RST, MAX_LENGTH_RST, MAX_GAP_RST);
        1: program_thresholds(16'd1, 16'd0, 16'd1, 16'd0);
        7: program_thresholds('1, '1, '1, '1);
        default: program_thresholds($urandom_range(0, 3) == 0 ? 16'hFFFF
                                                               : 16'($urandom_range(1, 2000)),
                                    16'($urandom_range(0, 12)), 16'($urandom_range(1, 24)),
                                    16'($urandom_range(0, 4)));
      endcase
      in_idle_max = (p == 0) ? 18 : (p == 1) ? 0 : pick_idle();
      out_idle_max = (p == 0) ? 18 : (p == 1) ? 0 : pick_idle();
      run_random_phase((p == 7) ? 40 : 130);
      settle();
    end

    // back-pressure: one-position islands at full rate while the output holds off
    program_thresholds(16'd50, 16'd0, 16'd3, 16'd0);
    in_idle_max = 0;
    out_idle_max = 3;
    hold_off_req = 1'b1;
    repeat (40) begin
      send_item(rand_cov(), 1'b0);
      send_item('0, 1'b0);
    end
    settle();

    if (mismatches == 0)
      $display("coverage_island_detector: match");
    else
      $display("coverage_island_detector: mismatch");
    $finish;
  end

endmodule
